FILE: hw/rtl/clcd4w_pkg.sv
// ============================================================================
// clcd4w_pkg
// Shared types, constants and helper functions of the character LCD 4-bit
// write controller.
// ============================================================================
package clcd4w_pkg;

   // queue geometry
   localparam int QUEUE_DEPTH   = 128;
   localparam int PTR_W         = $clog2(QUEUE_DEPTH);
   localparam int ENTRY_W       = 9;
   localparam int LINE_TWO_BASE = 64;

   // power-up sequence
   localparam logic [3:0] INIT_STEPS      = 4'd10;
   localparam logic [3:0] STEP_POWER_UP   = 4'd0;
   localparam logic [3:0] STEP_FIRST_WAKE = 4'd1;
   localparam logic [3:0] STEP_FOUR_BIT   = 4'd5;
   localparam logic [3:0] STEP_CLEAR      = 4'd7;

   // HD44780 instruction bytes
   localparam logic [7:0] LCD_CLEAR      = 8'h01;
   localparam logic [7:0] LCD_SET_DDRAM  = 8'h80;

   // request opcodes
   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_CHAR   = 2'd1;
   localparam logic [1:0] CMD_CURSOR = 2'd2;
   localparam logic [1:0] CMD_CLEAR  = 2'd3;

   // configuration register indexes
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_POWER_UP_WAIT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_WAKE_GAP = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLEAR_GAP      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_GAP       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE_HIGH    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_NIBBLE_SETTLE  = 3'd5;

   // timer load selection
   localparam logic [2:0] TL_COUNT      = 3'd0;
   localparam logic [2:0] TL_ENABLE     = 3'd1;
   localparam logic [2:0] TL_SETTLE     = 3'd2;
   localparam logic [2:0] TL_WAKE_GAP   = 3'd3;
   localparam logic [2:0] TL_CLEAR_GAP  = 3'd4;
   localparam logic [2:0] TL_STEP_GAP   = 3'd5;
   localparam logic [2:0] TL_POWER_UP   = 3'd6;

   // pin operations
   localparam logic [2:0] PIN_HOLD        = 3'd0;
   localparam logic [2:0] PIN_START_INIT  = 3'd1;
   localparam logic [2:0] PIN_START_QUEUE = 3'd2;
   localparam logic [2:0] PIN_HI_LOW      = 3'd3;
   localparam logic [2:0] PIN_LO_HIGH     = 3'd4;
   localparam logic [2:0] PIN_LO_LOW      = 3'd5;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] char_code;
      logic [1:0] row;
      logic [5:0] column;
   } req_type;

   typedef struct packed {
      logic       reg_select;
      logic       enable;
      logic [3:0] nibble;
      logic       init_done;
      logic       sending;
      logic       queue_full;
      logic       dropped;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic       load_item;
      logic       commit;
      logic [2:0] pin_op;
      logic [2:0] tl_sel;
      logic       pop;
      logic [7:0] init_byte;
      logic       init_done;
      logic       sending;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_tick;
      logic timer_expire;
      logic queue_empty;
      logic out_free;
   } dpath_status_type;

   // advance a ring pointer with wrap at the queue depth
   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   // instruction byte of each power-up step
   function automatic logic [7:0] init_byte(input logic [3:0] step);
      logic [7:0] b;
      unique case (step)
         4'd1, 4'd2, 4'd3: b = 8'h30;
         4'd4:             b = 8'h20;
         4'd5:             b = 8'h28;
         4'd6:             b = 8'h08;
         4'd7:             b = 8'h01;
         4'd8:             b = 8'h06;
         4'd9:             b = 8'h0C;
         default:          b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

FILE: hw/rtl/clcd4w_ram.sv
// ============================================================================
// clcd4w_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module clcd4w_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/clcd4w_dpath.sv
// ============================================================================
// clcd4w_dpath
// Datapath: request register, configuration registers, microsecond timer,
// pin levels, request queue and the response register.
// ============================================================================
module clcd4w_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  clcd4w_pkg::req_type                  req_data,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output clcd4w_pkg::rsp_type                  rsp_data,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [clcd4w_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [clcd4w_pkg::CSR_DATA_W-1:0]    csr_data,
   input  clcd4w_pkg::ctrl_cmd_type             ctrl_cmd,
   output clcd4w_pkg::dpath_status_type         dp_status
);

   localparam int PW = clcd4w_pkg::PTR_W;
   localparam int EW = clcd4w_pkg::ENTRY_W;

   clcd4w_pkg::req_type item_ff;

   logic [15:0] power_up_wait_ff, first_wake_gap_ff, clear_gap_ff, step_gap_ff;
   logic [7:0]  enable_high_ff, nibble_settle_ff;

   logic [15:0] time_left_ff, time_left_in;
   logic [7:0]  cur_byte_ff, cur_byte_in;
   logic        cur_rs_ff, cur_rs_in;
   logic        pin_rs_ff, pin_rs_in;
   logic        pin_en_ff, pin_en_in;
   logic [3:0]  pin_nib_ff, pin_nib_in;

   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;

   logic                rsp_valid_ff, rsp_valid_in;
   clcd4w_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic          want_push;
   logic [EW-1:0] push_entry;
   logic          full_now;
   logic          push;
   logic [EW-1:0] head_entry;
   logic [7:0]    cursor_addr;
   logic          timer_expire;
   logic [15:0]   timer_load;

   // hold the accepted request
   always_ff @(posedge clock) begin
      if (ctrl_cmd.load_item) begin
         item_ff <= req_data;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         power_up_wait_ff  <= 16'd50000;
         first_wake_gap_ff <= 16'd5000;
         clear_gap_ff      <= 16'd2000;
         step_gap_ff       <= 16'd1000;
         enable_high_ff    <= 8'd1;
         nibble_settle_ff  <= 8'd37;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            clcd4w_pkg::CSR_POWER_UP_WAIT:  power_up_wait_ff  <= csr_data;
            clcd4w_pkg::CSR_FIRST_WAKE_GAP: first_wake_gap_ff <= csr_data;
            clcd4w_pkg::CSR_CLEAR_GAP:      clear_gap_ff      <= csr_data;
            clcd4w_pkg::CSR_STEP_GAP:       step_gap_ff       <= csr_data;
            clcd4w_pkg::CSR_ENABLE_HIGH:    enable_high_ff    <= csr_data[7:0];
            clcd4w_pkg::CSR_NIBBLE_SETTLE:  nibble_settle_ff  <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // pick the timer reload value
   always_comb begin
      unique case (ctrl_cmd.tl_sel)
         clcd4w_pkg::TL_ENABLE:    timer_load = {8'd0, enable_high_ff};
         clcd4w_pkg::TL_SETTLE:    timer_load = {8'd0, nibble_settle_ff};
         clcd4w_pkg::TL_WAKE_GAP:  timer_load = first_wake_gap_ff;
         clcd4w_pkg::TL_CLEAR_GAP: timer_load = clear_gap_ff;
         clcd4w_pkg::TL_STEP_GAP:  timer_load = step_gap_ff;
         clcd4w_pkg::TL_POWER_UP:  timer_load = power_up_wait_ff;
         default:                  timer_load = '0;
      endcase
   end

   // count down on ticks, reload when the controller advances a phase
   assign timer_expire = (time_left_ff[15:1] == 15'd0);

   always_comb begin
      time_left_in = time_left_ff;
      if (ctrl_cmd.commit && (item_ff.cmd == clcd4w_pkg::CMD_TICK)) begin
         if (ctrl_cmd.tl_sel != clcd4w_pkg::TL_COUNT) begin
            time_left_in = timer_load;
         end else if (timer_expire) begin
            time_left_in = '0;
         end else begin
            time_left_in = time_left_ff - 16'd1;
         end
      end
   end

   // pin levels and the byte in flight
   always_comb begin
      cur_byte_in = cur_byte_ff;
      cur_rs_in   = cur_rs_ff;
      pin_rs_in   = pin_rs_ff;
      pin_en_in   = pin_en_ff;
      pin_nib_in  = pin_nib_ff;
      if (ctrl_cmd.commit) begin
         unique case (ctrl_cmd.pin_op)
            clcd4w_pkg::PIN_START_INIT: begin
               cur_byte_in = ctrl_cmd.init_byte;
               cur_rs_in   = 1'b0;
               pin_rs_in   = 1'b0;
               pin_en_in   = 1'b1;
               pin_nib_in  = ctrl_cmd.init_byte[7:4];
            end
            clcd4w_pkg::PIN_START_QUEUE: begin
               cur_byte_in = head_entry[7:0];
               cur_rs_in   = head_entry[8];
               pin_rs_in   = head_entry[8];
               pin_en_in   = 1'b1;
               pin_nib_in  = head_entry[7:4];
            end
            clcd4w_pkg::PIN_HI_LOW: begin
               pin_rs_in  = cur_rs_ff;
               pin_en_in  = 1'b0;
               pin_nib_in = cur_byte_ff[7:4];
            end
            clcd4w_pkg::PIN_LO_HIGH: begin
               pin_rs_in  = cur_rs_ff;
               pin_en_in  = 1'b1;
               pin_nib_in = cur_byte_ff[3:0];
            end
            clcd4w_pkg::PIN_LO_LOW: begin
               pin_rs_in  = cur_rs_ff;
               pin_en_in  = 1'b0;
               pin_nib_in = cur_byte_ff[3:0];
            end
            default: ;
         endcase
      end
   end

   // decode the queue entry of a request
   assign cursor_addr = 8'(clcd4w_pkg::LINE_TWO_BASE) + {2'b00, item_ff.column};

   always_comb begin
      want_push  = 1'b0;
      push_entry = '0;
      case (item_ff.cmd)
         clcd4w_pkg::CMD_CHAR: begin
            want_push  = 1'b1;
            push_entry = {1'b1, item_ff.char_code};
         end
         clcd4w_pkg::CMD_CURSOR: begin
            want_push  = (item_ff.row[1] == 1'b0);
            push_entry = {1'b0, clcd4w_pkg::LCD_SET_DDRAM |
                          (item_ff.row[0] ? cursor_addr : {2'b00, item_ff.column})};
         end
         clcd4w_pkg::CMD_CLEAR: begin
            want_push  = 1'b1;
            push_entry = {1'b0, clcd4w_pkg::LCD_CLEAR};
         end
         default: ;
      endcase
   end

   assign full_now = (clcd4w_pkg::next_ptr(wr_ptr_ff) == rd_ptr_ff);
   assign push     = ctrl_cmd.commit && want_push && !full_now;

   // advance the ring pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = clcd4w_pkg::next_ptr(wr_ptr_ff);
      end
      if (ctrl_cmd.commit && ctrl_cmd.pop) begin
         rd_ptr_in = clcd4w_pkg::next_ptr(rd_ptr_ff);
      end
   end

   clcd4w_ram #(
      .WIDTH (EW),
      .DEPTH (clcd4w_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (wr_ptr_ff),
      .wr_data (push_entry),
      .rd_addr (rd_ptr_ff),
      .rd_data (head_entry)
   );

   // response register
   always_comb begin
      rsp_data_in            = rsp_data_ff;
      rsp_data_in.reg_select = pin_rs_in;
      rsp_data_in.enable     = pin_en_in;
      rsp_data_in.nibble     = pin_nib_in;
      rsp_data_in.init_done  = ctrl_cmd.init_done;
      rsp_data_in.sending    = ctrl_cmd.sending;
      rsp_data_in.queue_full = (clcd4w_pkg::next_ptr(wr_ptr_in) == rd_ptr_in);
      rsp_data_in.dropped    = want_push && full_now;
      rsp_valid_in           = rsp_valid_ff && rsp_stall;
      if (ctrl_cmd.commit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_left_ff <= '0;
         cur_byte_ff  <= '0;
         cur_rs_ff    <= 1'b0;
         pin_rs_ff    <= 1'b0;
         pin_en_ff    <= 1'b0;
         pin_nib_ff   <= '0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         time_left_ff <= time_left_in;
         cur_byte_ff  <= cur_byte_in;
         cur_rs_ff    <= cur_rs_in;
         pin_rs_ff    <= pin_rs_in;
         pin_en_ff    <= pin_en_in;
         pin_nib_ff   <= pin_nib_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.commit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign dp_status.is_tick      = (item_ff.cmd == clcd4w_pkg::CMD_TICK);
   assign dp_status.timer_expire = timer_expire;
   assign dp_status.queue_empty  = (wr_ptr_ff == rd_ptr_ff);
   assign dp_status.out_free     = !rsp_valid_ff || !rsp_stall;

   // a write never lands on the entry at the head of a non-empty full queue
   assert property (@(posedge clock) disable iff (reset)
      push |-> !full_now)
      else $error("queue written while full");

   // a pop always leaves room in the queue
   assert property (@(posedge clock) disable iff (reset)
      (ctrl_cmd.commit && ctrl_cmd.pop) |=> !rsp_data_ff.queue_full)
      else $error("queue full right after a pop");

endmodule

FILE: hw/rtl/clcd4w_ctrl.sv
// ============================================================================
// clcd4w_ctrl
// Controller: request sequencing and the LCD phase / power-up state machine.
// ============================================================================
module clcd4w_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  clcd4w_pkg::dpath_status_type dp_status,
   output clcd4w_pkg::ctrl_cmd_type     ctrl_cmd
);

   // request sequencer states
   localparam logic SEQ_IDLE = 1'b0;
   localparam logic SEQ_EXEC = 1'b1;

   // LCD phases
   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_HI_EN  = 3'd1;
   localparam logic [2:0] PH_HI_SET = 3'd2;
   localparam logic [2:0] PH_LO_EN  = 3'd3;
   localparam logic [2:0] PH_LO_SET = 3'd4;
   localparam logic [2:0] PH_GAP    = 3'd5;

   logic       seq_ff, seq_in;
   logic [2:0] phase_ff, phase_in;
   logic [3:0] step_ff, step_in;
   logic       four_bit_ff, four_bit_in;

   logic       accept;
   logic       commit;
   logic       fire;
   logic [2:0] gap_sel;
   logic [2:0] pin_op;
   logic [2:0] tl_sel;
   logic       pop;

   assign accept = (seq_ff == SEQ_IDLE) && req_valid;
   assign commit = (seq_ff == SEQ_EXEC) && dp_status.out_free;
   assign fire   = commit && dp_status.is_tick && dp_status.timer_expire;

   // advance the request sequencer
   always_comb begin
      seq_in = seq_ff;
      unique case (seq_ff)
         SEQ_IDLE: if (accept) seq_in = SEQ_EXEC;
         SEQ_EXEC: if (commit) seq_in = SEQ_IDLE;
         default:  seq_in = SEQ_IDLE;
      endcase
   end

   // gap length depends on which power-up step just went out
   always_comb begin
      if (step_ff == clcd4w_pkg::STEP_FIRST_WAKE) begin
         gap_sel = clcd4w_pkg::TL_WAKE_GAP;
      end else if (step_ff == clcd4w_pkg::STEP_CLEAR) begin
         gap_sel = clcd4w_pkg::TL_CLEAR_GAP;
      end else begin
         gap_sel = clcd4w_pkg::TL_STEP_GAP;
      end
   end

   // phase machine: step once per expired timer on a tick
   always_comb begin
      phase_in    = phase_ff;
      step_in     = step_ff;
      four_bit_in = four_bit_ff;
      pin_op      = clcd4w_pkg::PIN_HOLD;
      tl_sel      = clcd4w_pkg::TL_COUNT;
      pop         = 1'b0;
      if (fire) begin
         unique case (phase_ff)
            PH_HI_EN: begin
               pin_op   = clcd4w_pkg::PIN_HI_LOW;
               tl_sel   = clcd4w_pkg::TL_SETTLE;
               phase_in = PH_HI_SET;
            end
            PH_HI_SET: begin
               if (four_bit_ff) begin
                  pin_op   = clcd4w_pkg::PIN_LO_HIGH;
                  tl_sel   = clcd4w_pkg::TL_ENABLE;
                  phase_in = PH_LO_EN;
               end else begin
                  tl_sel   = gap_sel;
                  phase_in = PH_GAP;
               end
            end
            PH_LO_EN: begin
               pin_op   = clcd4w_pkg::PIN_LO_LOW;
               tl_sel   = clcd4w_pkg::TL_SETTLE;
               phase_in = PH_LO_SET;
            end
            PH_LO_SET: begin
               tl_sel   = gap_sel;
               phase_in = PH_GAP;
            end
            PH_GAP: begin
               phase_in = PH_IDLE;
               if (step_ff < clcd4w_pkg::INIT_STEPS) begin
                  step_in = step_ff + 4'd1;
                  if (step_in == clcd4w_pkg::STEP_FOUR_BIT) begin
                     four_bit_in = 1'b1;
                  end
               end
            end
            default: begin
               // idle: power-up wait, next init byte, or next queued byte
               if (step_ff == clcd4w_pkg::STEP_POWER_UP) begin
                  tl_sel   = clcd4w_pkg::TL_POWER_UP;
                  phase_in = PH_GAP;
               end else if (step_ff < clcd4w_pkg::INIT_STEPS) begin
                  pin_op   = clcd4w_pkg::PIN_START_INIT;
                  tl_sel   = clcd4w_pkg::TL_ENABLE;
                  phase_in = PH_HI_EN;
               end else if (!dp_status.queue_empty) begin
                  pin_op   = clcd4w_pkg::PIN_START_QUEUE;
                  tl_sel   = clcd4w_pkg::TL_ENABLE;
                  pop      = 1'b1;
                  phase_in = PH_HI_EN;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff      <= SEQ_IDLE;
         phase_ff    <= PH_IDLE;
         step_ff     <= clcd4w_pkg::STEP_POWER_UP;
         four_bit_ff <= 1'b0;
      end else begin
         seq_ff      <= seq_in;
         phase_ff    <= phase_in;
         step_ff     <= step_in;
         four_bit_ff <= four_bit_in;
      end
   end

   assign req_stall = (seq_ff != SEQ_IDLE);

   assign ctrl_cmd.load_item = accept;
   assign ctrl_cmd.commit    = commit;
   assign ctrl_cmd.pin_op    = pin_op;
   assign ctrl_cmd.tl_sel    = tl_sel;
   assign ctrl_cmd.pop       = pop;
   assign ctrl_cmd.init_byte = clcd4w_pkg::init_byte(step_ff);
   assign ctrl_cmd.init_done = (step_in >= clcd4w_pkg::INIT_STEPS);
   assign ctrl_cmd.sending   = (phase_in != PH_IDLE) &&
                               (step_in != clcd4w_pkg::STEP_POWER_UP);

   // a queued byte is only taken from a non-empty queue after init
   assert property (@(posedge clock) disable iff (reset)
      pop |-> (!dp_status.queue_empty && (step_ff >= clcd4w_pkg::INIT_STEPS)))
      else $error("pop from empty queue or during init");

   // 4-bit mode comes on only once the 4-bit switch byte has gone out
   assert property (@(posedge clock) disable iff (reset)
      four_bit_ff |-> (step_ff >= clcd4w_pkg::STEP_FOUR_BIT))
      else $error("4-bit mode before the switch step");

   // state changes only on a committed tick with an expired timer
   assert property (@(posedge clock) disable iff (reset)
      !fire |=> ($stable(phase_ff) && $stable(step_ff)))
      else $error("phase moved without an expired tick");

   // an accepted request blocks the next one
   assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("request accepted back to back");

endmodule

FILE: hw/rtl/char_lcd_4bit_write_controller_core.sv
// ============================================================================
// char_lcd_4bit_write_controller_core
// Character LCD write controller for a 4-bit HD44780-style interface.
// ============================================================================
// Usage:
//   req_*  : one request per handshake: a microsecond tick (cmd 0) or a
//            character, cursor-position or clear request for the queue.
//   rsp_*  : one response per request: the pin levels (register select,
//            enable, D7..D4) after the request, plus init_done, sending,
//            queue_full and dropped.
//   csr_*  : register writes (index, data); csr_ready is always high.
//            Write only while no request is in flight.
// Timing: a request is taken in the idle state, worked in the execute
//   state and lands in the response register. The block takes no new
//   request until the last one has committed; a response stall holds it
//   in the execute state. The queue RAM read of the head entry is registered.
// Reset: pins low, queue empty, registers at their defaults, and the
//   power-up sequence starts on the first tick. The queue RAM needs no
//   clearing pass.
// Stall: while rsp_stall holds, the response stays in place; one more
//   request may be taken and then waits for the response register.
// ============================================================================
module char_lcd_4bit_write_controller_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  clcd4w_pkg::req_type               req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output clcd4w_pkg::rsp_type               rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [clcd4w_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [clcd4w_pkg::CSR_DATA_W-1:0] csr_data
);

   clcd4w_pkg::ctrl_cmd_type     ctrl_cmd;
   clcd4w_pkg::dpath_status_type dp_status;

   // registers are always writable
   assign csr_ready = 1'b1;

   clcd4w_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .ctrl_cmd  (ctrl_cmd)
   );

   clcd4w_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .ctrl_cmd  (ctrl_cmd),
      .dp_status (dp_status)
   );

endmodule
